[src/sbe_pkg.sv]
// Package for the stack bytecode executor: beat types, opcodes, status codes.
// No dependencies.
`default_nettype none
package sbe_pkg;
  localparam int unsigned StackDepthDef   = 256;
  localparam int unsigned ReturnDepthDef  = 64;
  localparam int unsigned ProgramDepthDef = 1024;
  localparam int unsigned CfgWidth        = 10;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0, KIND_ARG = 2'd1, KIND_ENTER = 2'd2, KIND_EXEC = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    OP_EXIT = 5'd0, OP_ADD = 5'd1, OP_PUSH = 5'd2, OP_POP = 5'd3, OP_PRINTI = 5'd4,
    OP_PRINTS = 5'd5, OP_LT = 5'd6, OP_LOAD = 5'd7, OP_STORE = 5'd8, OP_JZ = 5'd9,
    OP_JMP = 5'd10, OP_LOADB = 5'd11, OP_STOREB = 5'd12, OP_CALL = 5'd13,
    OP_RET = 5'd14, OP_SADD = 5'd15, OP_SPUSH = 5'd16, OP_SPOP = 5'd17,
    OP_SLOAD = 5'd18, OP_SSTORE = 5'd19, OP_SLOADB = 5'd20
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_UNDERFLOW = 3'd2, ST_BAD_INDEX = 3'd3,
    ST_BAD_OPCODE = 3'd4, ST_RET_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic {
    REG_WANT_RESULT = 1'b0, REG_ENTRY_ADDRESS = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] argument_value;
    logic [4:0]         opcode;
    logic signed [15:0] operand;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]         next_address;
    logic               fetch_valid;
    logic               halted;
    logic               print_valid;
    logic               print_kind;
    logic signed [15:0] print_value;
    logic               result_valid;
    logic signed [15:0] run_result;
    logic [2:0]         status;
  } out_beat_t;
endpackage
`default_nettype wire

[src/stack_bytecode_executor_top.sv]
// Stack bytecode executor top level: operand stack and return stack memories,
// sequencer and output register. Depends on sbe_pkg.
//
// Usage: in_valid_i/in_ready_o carry one beat per item (setup or instruction);
// out_valid_o/out_ready_i return exactly one result beat per item. The
// configuration port (cfg_we_i, cfg_index_i, cfg_data_i) writes want_result
// (index 0) and entry_address (index 1) with no handshake.
// Each item passes through a read step and an execute step: the read, done
// as the beat is accepted, takes the operand stack memory (the third entry
// from the top or the indexed entry) and the top return stack entry; the
// execute step computes, writes back and loads the output register, and
// waits while the output register holds a beat not yet taken. out_valid_o
// rises once the execute step is done. A new input beat is accepted only
// after the previous item has executed. The output register holds its beat
// while out_ready_i is low; a second item is read while a finished beat
// waits, and its result is taken into the output register as soon as it empties.
// Reset clears the counters, frame base, program counter, running flag and
// entry_address and sets want_result; memory contents stay undefined until
// written. The top-of-stack entry and the next entry down are kept in
// registers, so each item reads at most one indexed entry from memory.
`default_nettype none
module stack_bytecode_executor_top #(
  parameter int unsigned STACK_DEPTH   = sbe_pkg::StackDepthDef,
  parameter int unsigned RETURN_DEPTH  = sbe_pkg::ReturnDepthDef,
  parameter int unsigned PROGRAM_DEPTH = sbe_pkg::ProgramDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire sbe_pkg::in_beat_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output sbe_pkg::out_beat_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_index_i,
  input  wire logic [sbe_pkg::CfgWidth-1:0]   cfg_data_i
);
  import sbe_pkg::*;

  localparam int unsigned SW = $clog2(STACK_DEPTH);
  localparam int unsigned RW = $clog2(RETURN_DEPTH);
  localparam int unsigned PW = $clog2(PROGRAM_DEPTH);

  typedef enum logic [1:0] {S_IDLE = 2'b01, S_EXEC = 2'b10} state_e;

  // memories
  logic [15:0]   stk_mem [STACK_DEPTH];
  logic [PW:0]   ret_mem [RETURN_DEPTH];

  logic          want_q;
  logic [9:0]    entry_q;
  state_e        state_q;
  in_beat_t      item_q;
  logic [SW:0]   cnt_q, cnt_d;
  logic [15:0]   fb_q, fb_d;
  logic [PW-1:0] pc_q, pc_d;
  logic [RW:0]   rcnt_q, rcnt_d;
  logic [8:0]    argc_q, argc_d;
  logic          run_q, run_d;
  logic [15:0]   slot0_q, slot0_d;
  logic          ovalid_q;
  out_beat_t     obeat_q, obeat_d;

  logic [15:0]   rd_q;
  logic [PW:0]   rrd_q;
  logic [15:0]   top_q, top_d, nxt_q, nxt_d;

  logic          take, fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign take = in_valid_i && in_ready_o;
  assign fire = (state_q == S_EXEC) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = obeat_q;

  // index of the entry read in the read cycle
  logic signed [SW+17:0] ridx;
  logic [SW-1:0] raddr;
  logic          rd_b;
  always_comb begin
    rd_b = (in_data_i.opcode == OP_LOADB) || (in_data_i.opcode == OP_SLOADB)
        || (in_data_i.opcode == OP_STOREB);
    ridx = (SW+18)'(in_data_i.operand) + (rd_b ? (SW+18)'(fb_q) : '0);
    raddr = ridx[SW-1:0];
    if (in_data_i.opcode == OP_ADD || in_data_i.opcode == OP_SADD
        || in_data_i.opcode == OP_LT) begin
      raddr = SW'(cnt_q - (SW+1)'(3));
    end
    if (in_data_i.opcode == OP_POP || in_data_i.opcode == OP_SPOP
        || in_data_i.opcode == OP_PRINTI || in_data_i.opcode == OP_PRINTS
        || in_data_i.opcode == OP_JZ || in_data_i.opcode == OP_RET
        || in_data_i.opcode == OP_STORE || in_data_i.opcode == OP_SSTORE
        || in_data_i.opcode == OP_STOREB) begin
      raddr = SW'(cnt_q - (SW+1)'(3));
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rd_q  <= stk_mem[raddr];
      rrd_q <= ret_mem[RW'(rcnt_q - (RW+1)'(1))];
    end
  end

  // execute
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rwr_en;
  logic [RW-1:0] rwr_addr;
  logic [PW:0]   rwr_data;
  logic signed [SW+17:0] idx;
  logic          idx_ok, ended, is_b;
  logic [2:0]    st;
  logic [PW-1:0] pc_inc, pc_rel;
  logic [15:0]   mid;  // third entry from the top
  logic [15:0]   ld_val;

  always_comb begin
    cnt_d = cnt_q; fb_d = fb_q; pc_d = pc_q; rcnt_d = rcnt_q; argc_d = argc_q;
    run_d = run_q; slot0_d = slot0_q; top_d = top_q; nxt_d = nxt_q;
    wr_en = 1'b0; wr_addr = '0; wr_data = '0;
    rwr_en = 1'b0; rwr_addr = RW'(rcnt_q); rwr_data = '0;
    st = ST_OK; ended = 1'b0; obeat_d = '0;
    pc_inc = pc_q + PW'(1);
    pc_rel = pc_q + PW'(item_q.operand);
    mid = rd_q;
    is_b = (item_q.opcode == OP_LOADB) || (item_q.opcode == OP_SLOADB)
        || (item_q.opcode == OP_STOREB);
    idx = (SW+18)'(item_q.operand) + (is_b ? (SW+18)'(fb_q) : '0);
    idx_ok = !idx[SW+17] && (idx < (SW+18)'(cnt_q));
    // indexed read: entries at the top two and entry 0 live in registers
    if (idx_ok && idx == (SW+18)'(cnt_q) - 1) ld_val = top_q;
    else if (idx_ok && idx == (SW+18)'(cnt_q) - 2) ld_val = nxt_q;
    else if (idx == '0) ld_val = slot0_q;
    else ld_val = rd_q;
    if (item_q.kind == KIND_BEGIN) begin
      cnt_d = want_q ? (SW+1)'(1) : '0;
      rcnt_d = '0; argc_d = '0; fb_d = '0;
      if (want_q) begin
        slot0_d = '0; top_d = '0; wr_en = 1'b1; wr_addr = '0; wr_data = '0;
      end
      pc_d = PW'(entry_q); run_d = 1'b1;
    end else if (run_q) begin
      case (item_q.kind)
        KIND_ARG, KIND_ENTER: begin
          if (cnt_q >= (SW+1)'(STACK_DEPTH)) st = ST_OVERFLOW;
          else if (item_q.kind == KIND_ENTER && rcnt_q >= (RW+1)'(RETURN_DEPTH))
            st = ST_RET_OVERFLOW;
          else begin
            wr_en = 1'b1; wr_addr = SW'(cnt_q);
            wr_data = (item_q.kind == KIND_ARG) ? item_q.argument_value : '0;
            nxt_d = top_q; top_d = wr_data; cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) slot0_d = wr_data;
            if (item_q.kind == KIND_ARG) argc_d = argc_q + 9'd1;
            else begin
              rwr_en = 1'b1; rwr_data = '0; rcnt_d = rcnt_q + 1'b1;
              fb_d = 16'(cnt_q) + 16'd1;
            end
          end
        end
        default: begin
          pc_d = pc_inc;
          case (item_q.opcode)
            OP_EXIT: begin ended = 1'b1; pc_d = pc_q; end
            OP_ADD, OP_SADD, OP_LT: begin
              if (cnt_q < (SW+1)'(2)) st = ST_UNDERFLOW;
              else begin
                if (item_q.opcode == OP_LT)
                  top_d = ($signed(nxt_q) < $signed(top_q)) ? 16'd1 : 16'd0;
                else top_d = nxt_q + top_q;
                nxt_d = mid; cnt_d = cnt_q - 1'b1;
                wr_en = 1'b1; wr_addr = SW'(cnt_q - 2'd2); wr_data = top_d;
                if (cnt_q == (SW+1)'(2)) slot0_d = top_d;
              end
            end
            OP_PUSH, OP_SPUSH, OP_LOAD, OP_SLOAD, OP_LOADB, OP_SLOADB: begin
              if ((item_q.opcode == OP_LOAD || item_q.opcode == OP_SLOAD || is_b)
                  && !idx_ok) st = ST_BAD_INDEX;
              else if (cnt_q >= (SW+1)'(STACK_DEPTH)) st = ST_OVERFLOW;
              else begin
                wr_data = (item_q.opcode == OP_PUSH || item_q.opcode == OP_SPUSH)
                          ? item_q.operand : ld_val;
                wr_en = 1'b1; wr_addr = SW'(cnt_q);
                nxt_d = top_q; top_d = wr_data; cnt_d = cnt_q + 1'b1;
                if (cnt_q == '0) slot0_d = wr_data;
              end
            end
            OP_POP, OP_SPOP, OP_PRINTI, OP_PRINTS, OP_JZ: begin
              if (cnt_q < (SW+1)'(1)) st = ST_UNDERFLOW;
              else begin
                top_d = nxt_q; nxt_d = mid; cnt_d = cnt_q - 1'b1;
                if (item_q.opcode == OP_PRINTI || item_q.opcode == OP_PRINTS) begin
                  obeat_d.print_valid = 1'b1;
                  obeat_d.print_kind = (item_q.opcode == OP_PRINTS);
                  obeat_d.print_value = top_q;
                end
                if (item_q.opcode == OP_JZ && top_q == '0) pc_d = pc_rel;
              end
            end
            OP_STORE, OP_SSTORE, OP_STOREB: begin
              if (cnt_q < (SW+1)'(1)) st = ST_UNDERFLOW;
              else if (!idx_ok) st = ST_BAD_INDEX;
              else begin
                wr_en = 1'b1; wr_addr = SW'(idx); wr_data = top_q;
                if (idx == '0) slot0_d = top_q;
                top_d = (idx == (SW+18)'(cnt_q) - 2) ? top_q : nxt_q;
                nxt_d = (idx == (SW+18)'(cnt_q) - 3) ? top_q : mid;
                cnt_d = cnt_q - 1'b1;
              end
            end
            OP_JMP: pc_d = pc_rel;
            OP_CALL: begin
              if (cnt_q >= (SW+1)'(STACK_DEPTH)) st = ST_OVERFLOW;
              else if (rcnt_q >= (RW+1)'(RETURN_DEPTH)) st = ST_RET_OVERFLOW;
              else begin
                wr_en = 1'b1; wr_addr = SW'(cnt_q); wr_data = fb_q;
                nxt_d = top_q; top_d = wr_data; cnt_d = cnt_q + 1'b1;
                if (cnt_q == '0) slot0_d = wr_data;
                rwr_en = 1'b1; rwr_data = {1'b1, pc_inc}; rcnt_d = rcnt_q + 1'b1;
                fb_d = 16'(cnt_q) + 16'd1; pc_d = pc_rel;
              end
            end
            OP_RET: begin
              if (rcnt_q < (RW+1)'(1) || cnt_q < (SW+1)'(1)) st = ST_UNDERFLOW;
              else begin
                rcnt_d = rcnt_q - 1'b1; fb_d = top_q;
                top_d = nxt_q; nxt_d = mid; cnt_d = cnt_q - 1'b1;
                if (rrd_q[PW]) pc_d = rrd_q[PW-1:0];
                else begin ended = 1'b1; pc_d = pc_q; end
              end
            end
            default: st = ST_BAD_OPCODE;
          endcase
          if (st != ST_OK) pc_d = pc_q;
        end
      endcase
      if (st != ST_OK) begin
        cnt_d = cnt_q; fb_d = fb_q; rcnt_d = rcnt_q; top_d = top_q; nxt_d = nxt_q;
        argc_d = argc_q; slot0_d = slot0_q; wr_en = 1'b0; rwr_en = 1'b0;
        obeat_d.print_valid = 1'b0; obeat_d.print_kind = 1'b0;
        obeat_d.print_value = '0;
      end
      if (st != ST_OK || ended) begin
        obeat_d.halted = 1'b1; run_d = 1'b0;
        if (st == ST_OK) begin
          cnt_d = (32'(argc_q) < 32'(cnt_d)) ? cnt_d - (SW+1)'(argc_q) : '0;
          if (want_q) begin
            obeat_d.result_valid = 1'b1; obeat_d.run_result = slot0_d;
          end
        end
      end
    end
    obeat_d.status = st;
    obeat_d.next_address = 10'(pc_d);
    obeat_d.fetch_valid = run_d && (item_q.kind == KIND_ENTER
                                    || item_q.kind == KIND_EXEC);
  end

  always_ff @(posedge clk_i) begin
    if (fire && wr_en) stk_mem[wr_addr] <= wr_data;
    if (fire && rwr_en) ret_mem[rwr_addr] <= rwr_data;
    if (fire) begin
      obeat_q <= obeat_d; slot0_q <= slot0_d; top_q <= top_d; nxt_q <= nxt_d;
    end
    if (take) item_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ovalid_q <= 1'b0; cnt_q <= '0; fb_q <= '0; pc_q <= '0;
      rcnt_q <= '0; argc_q <= '0; run_q <= 1'b0; want_q <= 1'b1; entry_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_WANT_RESULT) want_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_index_i == REG_ENTRY_ADDRESS) entry_q <= cfg_data_i;
      if (fire) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (take) state_q <= S_EXEC;
        S_EXEC: if (fire) begin
          state_q <= S_IDLE;
          cnt_q <= cnt_d; fb_q <= fb_d; pc_q <= pc_d; rcnt_q <= rcnt_d;
          argc_q <= argc_d; run_q <= run_d;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ret_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= (RW+1)'(RETURN_DEPTH)) else $error("return count out of range");
  a_stk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (SW+1)'(STACK_DEPTH)) else $error("stack count out of range");
  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> ovalid_q) else $error("result beat lost");
  a_halt_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && obeat_d.halted) |=> !run_q) else $error("halt left block running");
`endif
endmodule
`default_nettype wire
